>>> sv/masked_2x2_average_downsample_core_assert.svh
// Assertion macros shared by the downsampler modules
`ifndef MASKED_2X2_AVERAGE_DOWNSAMPLE_CORE_ASSERT_SVH
`define MASKED_2X2_AVERAGE_DOWNSAMPLE_CORE_ASSERT_SVH

// Property checked on every rising edge, ignored while in reset
`define M2AD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold
`define M2AD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> sv/m2ad_pkg.sv
// Shared types, widths and the reciprocal table of the 2x2 downsampler
package m2ad_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int FRAC_BITS = 8;
  localparam int CH_W      = 16;
  localparam int PSUM_W    = CH_W + 1;
  localparam int TSUM_W    = CH_W + 2;
  localparam int WID_W     = 13;
  localparam int HGT_W     = 16;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 16;
  localparam int ADDR_W    = $clog2(MAX_WIDTH / 2);
  localparam int DEPTH     = MAX_WIDTH / 2;
  localparam int RECIP_SH  = 20;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam int PROD_W    = TSUM_W + RECIP_W;

  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(1024);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // one line store entry: channel sums of the top pair and its valid count
  typedef struct packed {
    logic [PSUM_W-1:0] blue;
    logic [PSUM_W-1:0] green;
    logic [PSUM_W-1:0] red;
    logic [1:0]        cnt;
  } pair_t;

  typedef struct packed {
    logic step;
    logic sum_en;
    logic mul_en;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic out_busy;
  } stat_t;

  // ceil(2^20 / n): exact floor division for sums below 2^19
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      3'd1:    r = RECIP_W'(1 << RECIP_SH);
      3'd2:    r = RECIP_W'(1 << (RECIP_SH - 1));
      3'd3:    r = RECIP_W'(((1 << RECIP_SH) + 2) / 3);
      3'd4:    r = RECIP_W'(1 << (RECIP_SH - 2));
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/m2ad_ctrl.sv
// Sequencer for line store read, block sum, reciprocal multiply and output load
module m2ad_ctrl import m2ad_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  `include "masked_2x2_average_downsample_core_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_MUL  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_stall   = (state != S_IDLE);
  assign cmd.step   = in_valid && (state == S_IDLE);
  assign cmd.sum_en = (state == S_SUM);
  assign cmd.mul_en = (state == S_MUL);
  assign cmd.load   = (state == S_PUSH) && !st.out_busy;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.step && st.produce) state_next = S_SUM;
      end
      S_SUM:  state_next = S_MUL;
      S_MUL:  state_next = S_PUSH;
      S_PUSH: begin
        if (!st.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `M2AD_ASSERT(a_block_starts, (cmd.step && st.produce) |=> (state == S_SUM), "block item not sequenced")
  `M2AD_ASSERT(a_sum_to_mul, (state == S_SUM) |=> (state == S_MUL), "sum not followed by multiply")
  `M2AD_ASSERT(a_push_waits, (state == S_PUSH && st.out_busy) |=> (state == S_PUSH), "result dropped while output full")

endmodule

>>> sv/m2ad_dp.sv
// Datapath: counters, left pixel, line store, block sum, mean and output register
module m2ad_dp import m2ad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             st,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [HGT_W-1:0]  cfg_data,
  input  logic [CH_W-1:0]   blue_in,
  input  logic [CH_W-1:0]   green_in,
  input  logic [CH_W-1:0]   red_in,
  input  logic              pixel_valid,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [CH_W-1:0]   blue_out,
  output logic [CH_W-1:0]   green_out,
  output logic [CH_W-1:0]   red_out,
  output logic              block_valid,
  output logic              frame_last
);

  `include "masked_2x2_average_downsample_core_assert.svh"

  logic [WID_W-1:0]  width_reg;
  logic [HGT_W-1:0]  height_reg;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [CH_W-1:0]   left_b, left_g, left_r;
  logic              left_v;

  logic [WID_W-1:0]  w_eff, even_w;
  logic [HGT_W-1:0]  h_eff, even_h;
  logic              in_range, last_pos;
  pair_t             pair_cur, pair_hold, top;
  logic              last_hold;
  logic [ADDR_W-1:0] addr;

  pair_t             store [DEPTH];

  logic [TSUM_W-1:0] sum_b, sum_g, sum_r;
  logic [2:0]        cnt_sum;
  logic [2:0]        cnt_total;
  logic              last_sum;
  logic [PROD_W-1:0] prod_b, prod_g, prod_r;
  logic [CH_W-1:0]   mean_b, mean_g, mean_r;
  logic              mean_v, last_mul;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
        REG_HEIGHT: height_reg <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_reg;
    if (width_reg < WID_W'(2))         w_eff = WID_W'(2);
    if (width_reg > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
    h_eff = (height_reg < HGT_W'(2)) ? HGT_W'(2) : height_reg;
    even_w = {w_eff[WID_W-1:1], 1'b0};
    even_h = {h_eff[HGT_W-1:1], 1'b0};
  end

  assign in_range   = col[0] && ({1'b0, col} < even_w) && (row < even_h);
  assign last_pos   = ({1'b0, col} == even_w - WID_W'(1)) && (row == even_h - HGT_W'(1));
  assign st.produce = in_range && row[0];
  assign st.out_busy = out_valid && out_stall;
  assign addr       = col[COL_W-1:1];

  // pair sum of left pixel and the one arriving now
  always_comb begin
    pair_cur.blue  = (left_v ? {1'b0, left_b} : '0) + (pixel_valid ? {1'b0, blue_in} : '0);
    pair_cur.green = (left_v ? {1'b0, left_g} : '0) + (pixel_valid ? {1'b0, green_in} : '0);
    pair_cur.red   = (left_v ? {1'b0, left_r} : '0) + (pixel_valid ? {1'b0, red_in} : '0);
    pair_cur.cnt   = {1'b0, left_v} + {1'b0, pixel_valid};
  end

  // raster position and left pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      left_b <= '0;
      left_g <= '0;
      left_r <= '0;
      left_v <= 1'b0;
    end else if (cmd.step) begin
      if (!col[0]) begin
        left_b <= blue_in;
        left_g <= green_in;
        left_r <= red_in;
        left_v <= pixel_valid;
      end
      if ({1'b0, col} + WID_W'(1) >= w_eff) begin
        col <= '0;
        row <= ({1'b0, row} + 17'd1 >= {1'b0, h_eff}) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // line store: top row writes, bottom row reads
  always_ff @(posedge clk) begin
    if (cmd.step && in_range && !row[0]) store[addr] <= pair_cur;
    if (cmd.step && st.produce) begin
      top       <= store[addr];
      pair_hold <= pair_cur;
      last_hold <= last_pos;
    end
  end

  // block sums with half the count added for rounding
  assign cnt_total = {1'b0, top.cnt} + {1'b0, pair_hold.cnt};

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_b    <= {1'b0, top.blue}  + {1'b0, pair_hold.blue}  + TSUM_W'(cnt_total[2:1]);
      sum_g    <= {1'b0, top.green} + {1'b0, pair_hold.green} + TSUM_W'(cnt_total[2:1]);
      sum_r    <= {1'b0, top.red}   + {1'b0, pair_hold.red}   + TSUM_W'(cnt_total[2:1]);
      cnt_sum  <= cnt_total;
      last_sum <= last_hold;
    end
  end

  // divide by the count through its reciprocal
  assign prod_b = PROD_W'(sum_b) * PROD_W'(recip(cnt_sum));
  assign prod_g = PROD_W'(sum_g) * PROD_W'(recip(cnt_sum));
  assign prod_r = PROD_W'(sum_r) * PROD_W'(recip(cnt_sum));

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      mean_b   <= prod_b[RECIP_SH+CH_W-1:RECIP_SH];
      mean_g   <= prod_g[RECIP_SH+CH_W-1:RECIP_SH];
      mean_r   <= prod_r[RECIP_SH+CH_W-1:RECIP_SH];
      mean_v   <= (cnt_sum != 3'd0);
      last_mul <= last_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)                out_valid <= 1'b0;
    else if (cmd.load)      out_valid <= 1'b1;
    else if (!out_stall)    out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blue_out    <= mean_b;
      green_out   <= mean_g;
      red_out     <= mean_r;
      block_valid <= mean_v;
      frame_last  <= last_mul;
    end
  end

  `M2AD_ASSERT(a_load_shows, cmd.load |=> out_valid, "loaded result not presented")
  `M2AD_NEVER(a_empty_zero, out_valid && !block_valid && (blue_out != '0 || green_out != '0 || red_out != '0), "empty block with nonzero mean")
  `M2AD_NEVER(a_load_full, cmd.load && out_valid && out_stall, "output overwritten while stalled")

endmodule

>>> sv/masked_2x2_average_downsample_core.sv
// Sequence: a pixel that completes a 2x2 block registers its pairs, then block sum, mean and output.
// Throughput: one pixel per cycle, except block-completing pixels (odd row, odd column),
// which hold the input through block sum, reciprocal multiply and output load.
// A stalled output holds the input further until the output register frees.
// Reset (rst, synchronous): position and left pixel cleared, width 4096, height 1024;
// the line store is not cleared and needs no clearing pass.
module masked_2x2_average_downsample_core import m2ad_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [HGT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CH_W-1:0]  blue_in,
  input  logic [CH_W-1:0]  green_in,
  input  logic [CH_W-1:0]  red_in,
  input  logic             pixel_valid,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CH_W-1:0]  blue_out,
  output logic [CH_W-1:0]  green_out,
  output logic [CH_W-1:0]  red_out,
  output logic             block_valid,
  output logic             frame_last
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  m2ad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  m2ad_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .blue_in     (blue_in),
    .green_in    (green_in),
    .red_in      (red_in),
    .pixel_valid (pixel_valid),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .blue_out    (blue_out),
    .green_out   (green_out),
    .red_out     (red_out),
    .block_valid (block_valid),
    .frame_last  (frame_last)
  );

endmodule
